[rtl/stc_pkg.sv]
// Shared types and constants for the scrolling text console buffer.
package stc_pkg;

    localparam int ROWS    = 8;
    localparam int COLS    = 32;
    localparam int ROW_W   = $clog2(ROWS);
    localparam int COL_W   = $clog2(COLS);
    localparam int LEN_W   = $clog2(COLS + 1);
    localparam int FILL_W  = $clog2(ROWS + 1);
    localparam int LINE_AW = $clog2(ROWS * COLS);

    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;

    typedef enum logic [1:0] {
        OP_PUT  = 2'd0,
        OP_READ = 2'd1,
        OP_MARK = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TAB,
        ST_COPY,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] char_in;
        logic [2:0] row_sel;
        logic [4:0] col_sel;
    } t_cmd;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [5:0] row_len;
        logic       row_dirty;
        logic       panel_full;
        logic [3:0] dirty_rows;
    } t_result;

endpackage

[rtl/stc_ram.sv]
// Generic simple dual-port RAM with registered read.
module stc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/scrolling_text_console_buffer.sv]
// Top level of the scrolling text console buffer.
//
// Command channel: drive i_cmd and raise start; the command transfers on a
// rising edge where start is high and busy is low. busy stays high until the
// result has been shown.
// Result channel: o_result is valid for exactly one cycle while o_done is
// high; the receiver cannot stall it, so it must capture it in that cycle.
// Sequence after the transfer edge:
//   read, mark, ordinary put, backspace, return: execute, then show the
//   result, then return to idle, in which the next command transfers;
//   tab: one pending-line write per space, then the result;
//   newline: the copy of the pending line into the line store, one
//   character per cycle through the single write port of the line
//   memory, then the result; an empty line copies no characters.
// Reset (synchronous, active low) empties the pending line, clears all row
// lengths, sets every row dirty and returns the panel to its top row. The
// character memories are not cleared; they are only read below the lengths.
module scrolling_text_console_buffer
    import stc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_cmd    i_cmd,
    output logic    busy,
    output logic    o_done,
    output t_result o_result
);

    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [LEN_W-1:0]   r_line_len [ROWS];
    logic [LEN_W-1:0]   n_line_len [ROWS];
    logic [ROWS-1:0]    r_dirty, n_dirty;
    logic [FILL_W-1:0]  r_filled, n_filled;
    logic [ROW_W-1:0]   r_top, n_top;
    logic [LEN_W-1:0]   r_pend_len, n_pend_len;
    logic [LEN_W-1:0]   r_len, n_len;
    logic               r_row_dirty, n_row_dirty;
    logic               r_cell_ok, n_cell_ok;
    logic [ROW_W-1:0]   r_phys, n_phys;
    logic [LEN_W-1:0]   r_copy_len, n_copy_len;
    logic [LEN_W-1:0]   r_idx, n_idx;
    logic               r_wv, n_wv;
    logic [COL_W-1:0]   r_wcol, n_wcol;
    logic [1:0]         r_tab_cnt, n_tab_cnt;

    logic               pend_we;
    logic [COL_W-1:0]   pend_waddr;
    logic [7:0]         pend_wdata;
    logic [COL_W-1:0]   pend_raddr;
    logic [7:0]         pend_rdata;
    logic               line_we;
    logic [LINE_AW-1:0] line_waddr;
    logic [LINE_AW-1:0] line_raddr;
    logic [7:0]         line_rdata;

    logic               row_ok;
    logic [ROW_W-1:0]   sel_phys;
    logic [FILL_W-1:0]  dirty_cnt;

    function automatic logic [ROW_W-1:0] vis_to_phys(
        input logic [ROW_W-1:0] top,
        input logic [ROW_W-1:0] vis
    );
        logic [ROW_W:0] sum;
        sum = {1'b0, top} + {1'b0, vis};
        if (32'(sum) >= ROWS) begin
            sum = sum - (ROW_W + 1)'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    stc_ram #(.WIDTH(8), .DEPTH(COLS)) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (pend_we),
        .i_waddr (pend_waddr),
        .i_wdata (pend_wdata),
        .i_raddr (pend_raddr),
        .o_rdata (pend_rdata)
    );

    stc_ram #(.WIDTH(8), .DEPTH(ROWS * COLS)) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (line_waddr),
        .i_wdata (pend_rdata),
        .i_raddr (line_raddr),
        .o_rdata (line_rdata)
    );

    assign row_ok     = (32'(r_cmd.row_sel) < ROWS);
    assign sel_phys   = vis_to_phys(r_top, r_cmd.row_sel[ROW_W-1:0]);
    assign line_raddr = LINE_AW'(sel_phys) * LINE_AW'(COLS) + LINE_AW'(r_cmd.col_sel);
    assign line_waddr = LINE_AW'(r_phys) * LINE_AW'(COLS) + LINE_AW'(r_wcol);
    assign line_we    = (r_state == ST_COPY) && r_wv;
    assign pend_raddr = r_idx[COL_W-1:0];

    always_comb begin
        dirty_cnt = '0;
        for (int i = 0; i < ROWS; i++) begin
            dirty_cnt = dirty_cnt + FILL_W'(r_dirty[i]);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_cmd.opcode == OP_PUT && r_cmd.char_in == CH_NEWLINE) begin
                    n_state = ST_COPY;
                end else if (r_cmd.opcode == OP_PUT && r_cmd.char_in == CH_TAB) begin
                    n_state = ST_TAB;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_TAB: begin
                if (r_tab_cnt == 2'd3) begin
                    n_state = ST_OUT;
                end
            end
            ST_COPY: begin
                if (r_idx == r_copy_len && !r_wv) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_cmd       = r_cmd;
        n_line_len  = r_line_len;
        n_dirty     = r_dirty;
        n_filled    = r_filled;
        n_top       = r_top;
        n_pend_len  = r_pend_len;
        n_len       = r_len;
        n_row_dirty = r_row_dirty;
        n_cell_ok   = r_cell_ok;
        n_phys      = r_phys;
        n_copy_len  = r_copy_len;
        n_idx       = r_idx;
        n_wv        = 1'b0;
        n_wcol      = r_wcol;
        n_tab_cnt   = r_tab_cnt;
        pend_we     = 1'b0;
        pend_waddr  = r_pend_len[COL_W-1:0];
        pend_wdata  = r_cmd.char_in;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cmd = i_cmd;
                end
            end
            ST_EXEC: begin
                // Capture the addressed row as it was before this item.
                n_len       = row_ok ? r_line_len[sel_phys] : '0;
                n_row_dirty = row_ok ? r_dirty[r_cmd.row_sel[ROW_W-1:0]] : 1'b0;
                n_cell_ok   = row_ok && (LEN_W'(r_cmd.col_sel) < r_line_len[sel_phys]);
                case (r_cmd.opcode)
                    OP_PUT: begin
                        case (r_cmd.char_in)
                            CH_NEWLINE: begin
                                if (32'(r_filled) < ROWS) begin
                                    n_phys = vis_to_phys(r_top, r_filled[ROW_W-1:0]);
                                    n_dirty[r_filled[ROW_W-1:0]] = 1'b1;
                                    n_filled = r_filled + 1'b1;
                                end else begin
                                    // Scroll: the oldest row becomes the new bottom row.
                                    n_phys  = r_top;
                                    n_top   = vis_to_phys(r_top, ROW_W'(1));
                                    n_dirty = '1;
                                end
                                n_line_len[n_phys] = r_pend_len;
                                n_copy_len = r_pend_len;
                                n_pend_len = '0;
                                n_idx      = '0;
                            end
                            CH_RETURN: begin
                            end
                            CH_BACKSPACE: begin
                                if (r_pend_len != '0) begin
                                    n_pend_len = r_pend_len - 1'b1;
                                end
                            end
                            CH_TAB: begin
                                n_tab_cnt = '0;
                            end
                            default: begin
                                if (r_cmd.char_in >= CH_SPACE && 32'(r_pend_len) < COLS) begin
                                    pend_we    = 1'b1;
                                    n_pend_len = r_pend_len + 1'b1;
                                end
                            end
                        endcase
                    end
                    OP_MARK: begin
                        if (row_ok) begin
                            n_dirty[r_cmd.row_sel[ROW_W-1:0]] = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_TAB: begin
                pend_wdata = CH_SPACE;
                if (32'(r_pend_len) < COLS) begin
                    pend_we    = 1'b1;
                    n_pend_len = r_pend_len + 1'b1;
                end
                n_tab_cnt = r_tab_cnt + 1'b1;
            end
            ST_COPY: begin
                // Read pending[idx] now, write it to the line store next cycle.
                if (r_idx != r_copy_len) begin
                    n_wv   = 1'b1;
                    n_wcol = r_idx[COL_W-1:0];
                    n_idx  = r_idx + 1'b1;
                end
            end
            ST_OUT: begin
            end
            default: begin
            end
        endcase

        busy                  = (r_state != ST_IDLE);
        o_done                = (r_state == ST_OUT);
        o_result.cell_char    = (r_cmd.opcode == OP_READ && r_cell_ok) ? line_rdata : 8'h00;
        o_result.row_len      = 6'(r_len);
        o_result.row_dirty    = r_row_dirty;
        o_result.panel_full   = (32'(r_filled) >= ROWS);
        o_result.dirty_rows   = 4'(dirty_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_dirty    <= '1;
            r_filled   <= '0;
            r_top      <= '0;
            r_pend_len <= '0;
            r_wv       <= 1'b0;
            for (int i = 0; i < ROWS; i++) begin
                r_line_len[i] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_dirty    <= n_dirty;
            r_filled   <= n_filled;
            r_top      <= n_top;
            r_pend_len <= n_pend_len;
            r_wv       <= n_wv;
            r_line_len <= n_line_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_len       <= n_len;
        r_row_dirty <= n_row_dirty;
        r_cell_ok   <= n_cell_ok;
        r_phys      <= n_phys;
        r_copy_len  <= n_copy_len;
        r_idx       <= n_idx;
        r_wcol      <= n_wcol;
        r_tab_cnt   <= n_tab_cnt;
    end

endmodule

[rtl/stc_chk.sv]
// Port-level checks for the scrolling text console buffer, bound to the top level.
module stc_chk
    import stc_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input t_cmd    i_cmd,
    input logic    busy,
    input logic    o_done,
    input t_result o_result
);

    // A transfer always makes the block busy on the next cycle.
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after command transfer");

    // No result can appear in the cycle right after a transfer.
    a_no_early_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_done)
        else $error("result strobe too early after transfer");

    // The result is shown while still busy, and only for one cycle.
    a_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe while idle");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!o_done && !busy))
        else $error("result strobe held longer than one cycle");

    // Dirty count shown with a result never exceeds the number of rows.
    a_dirty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (32'(o_result.dirty_rows) <= ROWS))
        else $error("dirty row count out of range");

endmodule

bind scrolling_text_console_buffer stc_chk u_stc_chk (.*);
